[rtl/bgpw_pkg.sv]
package bgpw_pkg;

   localparam logic [3:0] ALL_TRIED = 4'hF;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef enum logic [2:0] {
      ST_REPEAT    = 3'd0,
      ST_REJECTED  = 3'd1,
      ST_ADVANCED  = 3'd2,
      ST_BACKTRACK = 3'd3,
      ST_DONE      = 3'd4,
      ST_STUCK     = 3'd5,
      ST_READ      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_POP     = 2'd2
   } op_type;

   // facts about the walker state that the decision needs
   typedef struct packed {
      logic       is_read;
      logic [1:0] dir;
      logic       done;
      logic       completes;
      logic [3:0] tried;
      logic       in_bounds;
      logic       target_empty;
      logic       stack_room;
      logic       stack_empty;
      logic [1:0] top_dir;
      logic [3:0] top_tried;
   } step_in_type;

   typedef struct packed {
      status_type status;
      op_type     op;
      logic [3:0] tried_next;
      logic [3:0] push_tried;
      logic [1:0] moved_dir;
   } step_out_type;

endpackage

[rtl/bgpw_req_if.sv]
interface bgpw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [1:0] direction;
   logic [7:0] cell_req;

   modport source (output valid, output action, output direction, output cell_req,
                   input ready);
   modport sink   (input valid, input action, input direction, input cell_req,
                   output ready);
endinterface

[rtl/bgpw_rsp_if.sv]
interface bgpw_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] position;
   logic [4:0] label_count;
   logic [1:0] moved_direction;
   logic [4:0] cell_label;

   modport source (output valid, output status, output position, output label_count,
                   output moved_direction, output cell_label, input ready);
   modport sink   (input valid, input status, input position, input label_count,
                   input moved_direction, input cell_label, output ready);
endinterface

[rtl/bgpw_step.sv]
module bgpw_step (
   input  bgpw_pkg::step_in_type  step_i,
   output bgpw_pkg::step_out_type step_o
);

   logic [3:0] dir_bit;
   logic [3:0] tried_or;
   logic       need_pop;

   assign dir_bit  = 4'b0001 << step_i.dir;
   assign tried_or = step_i.tried | dir_bit;

   always_comb begin
      step_o.status     = bgpw_pkg::ST_REPEAT;
      step_o.op         = bgpw_pkg::OP_NONE;
      step_o.tried_next = step_i.tried;
      step_o.push_tried = tried_or;
      step_o.moved_dir  = 2'd0;
      need_pop          = 1'b0;

      if (step_i.is_read) begin
         step_o.status = bgpw_pkg::ST_READ;
      end else if (step_i.done) begin
         step_o.status = bgpw_pkg::ST_DONE;
      end else if (step_i.tried == bgpw_pkg::ALL_TRIED) begin
         need_pop = 1'b1;
      end else if ((step_i.tried & dir_bit) != 4'd0) begin
         step_o.status = bgpw_pkg::ST_REPEAT;
      end else begin
         step_o.tried_next = tried_or;
         if (step_i.in_bounds && step_i.target_empty && step_i.stack_room) begin
            step_o.op         = bgpw_pkg::OP_ADVANCE;
            step_o.tried_next = 4'd0;
            step_o.moved_dir  = step_i.dir;
            step_o.status     = step_i.completes ? bgpw_pkg::ST_DONE
                                                 : bgpw_pkg::ST_ADVANCED;
         end else if (tried_or == bgpw_pkg::ALL_TRIED) begin
            need_pop = 1'b1;
         end else begin
            step_o.status = bgpw_pkg::ST_REJECTED;
         end
      end

      // dead end: undo the last move, or report stuck with an empty stack
      if (need_pop) begin
         if (step_i.stack_empty) begin
            step_o.status = bgpw_pkg::ST_STUCK;
         end else begin
            step_o.status     = bgpw_pkg::ST_BACKTRACK;
            step_o.op         = bgpw_pkg::OP_POP;
            step_o.tried_next = step_i.top_tried;
            step_o.moved_dir  = step_i.top_dir;
         end
      end
   end

endmodule

[rtl/backtracking_grid_path_walker.sv]
// Randomized backtracking self-avoiding walk on a GRID_SIDE x GRID_SIDE grid.
// The path starts at corner cell 0 (label 1). Each draw item (action 0) tries
// one direction from the head; a free neighbor gets the next label and the
// move is pushed, and once all four directions fail the last move is undone.
// A read item (action 1) returns the label of one cell. Every item gives
// exactly one response. The transfer edge issues the grid memory read (target
// cell or requested cell) and the stack-top read. Once the response register
// is free or being emptied, an edge decides, writes the grid and stack and
// loads the response register. The next request is taken once the current
// item is decided, even while its response still waits on rsp_ch. After reset
// the grid memory is swept once, one cell per cycle, over GRID_SIDE*GRID_SIDE
// cells (256 by default), during which req_ch.ready stays low.
module backtracking_grid_path_walker #(
   parameter int GRID_SIDE = 16,
   parameter int PATH_LEN  = 26
) (
   input logic        clock,
   input logic        reset,
   bgpw_req_if.sink   req_ch,
   bgpw_rsp_if.source rsp_ch
);

   localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AW        = $clog2(NUM_CELLS);     // cell address
   localparam int RW        = $clog2(GRID_SIDE);     // row / column
   localparam int CW        = $clog2(PATH_LEN + 1);  // labels, counts
   localparam int SW        = $clog2(PATH_LEN);      // stack index

   // grid memory and move stack ({dir, tried} per entry)
   logic [CW-1:0] grid_mem [NUM_CELLS];
   logic [5:0]    stack_mem [PATH_LEN];

   // walker state
   logic [AW-1:0] head_pos_ff, head_pos_in;
   logic [RW-1:0] head_row_ff, head_row_in;
   logic [RW-1:0] head_col_ff, head_col_in;
   logic [CW-1:0] placed_ff, placed_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [3:0]    tried_ff;

   // sweep after reset
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // item in flight
   logic          busy_ff, busy_in;
   logic          act_ff;
   logic [1:0]    dir_ff;
   logic          inb_ff;
   logic          rdz_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] grid_rd_ff;
   logic [5:0]    stk_rd_ff;

   // response register
   logic          rsp_valid_ff;
   logic [2:0]    status_ff;
   logic [7:0]    position_ff;
   logic [4:0]    count_ff;
   logic [1:0]    moved_ff;
   logic [4:0]    label_ff;

   logic          accept;
   logic          proc;
   logic [AW-1:0] tgt_addr;
   logic          tgt_inb;
   logic [AW-1:0] req_addr;
   logic          req_in_range;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] stk_rd_idx;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] wr_data;

   bgpw_pkg::step_in_type  step_in;
   bgpw_pkg::step_out_type step_out;

   // ---------------------------------------------------------------- handshakes
   assign req_ch.ready = !busy_ff && !clr_active_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   // decide when the response register is free or being emptied
   assign proc         = busy_ff && (!rsp_valid_ff || rsp_ch.ready);

   // ---------------------------------------------------------------- read address
   always_comb begin
      tgt_addr = head_pos_ff;
      tgt_inb  = 1'b0;
      case (req_ch.direction)
         bgpw_pkg::DIR_NORTH: begin
            tgt_addr = head_pos_ff - AW'(GRID_SIDE);
            tgt_inb  = head_row_ff != RW'(0);
         end
         bgpw_pkg::DIR_SOUTH: begin
            tgt_addr = head_pos_ff + AW'(GRID_SIDE);
            tgt_inb  = head_row_ff != RW'(GRID_SIDE - 1);
         end
         bgpw_pkg::DIR_EAST: begin
            tgt_addr = head_pos_ff + AW'(1);
            tgt_inb  = head_col_ff != RW'(GRID_SIDE - 1);
         end
         default: begin
            tgt_addr = head_pos_ff - AW'(1);
            tgt_inb  = head_col_ff != RW'(0);
         end
      endcase
   end

   assign req_addr     = AW'(req_ch.cell_req);
   assign req_in_range = 32'(req_ch.cell_req) < 32'(NUM_CELLS);
   assign rd_addr      = req_ch.action ? req_addr : tgt_addr;
   assign stk_rd_idx   = SW'(depth_ff - CW'(1));

   // ---------------------------------------------------------------- capture
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff     <= req_ch.action;
         dir_ff     <= req_ch.direction;
         inb_ff     <= tgt_inb;
         rdz_ff     <= !req_in_range;
         addr_ff    <= rd_addr;
         grid_rd_ff <= grid_mem[rd_addr];
         stk_rd_ff  <= stack_mem[stk_rd_idx];
      end
   end

   // ---------------------------------------------------------------- decision
   always_comb begin
      step_in.is_read      = act_ff;
      step_in.dir          = dir_ff;
      step_in.done         = placed_ff == CW'(PATH_LEN);
      step_in.completes    = placed_ff == CW'(PATH_LEN - 1);
      step_in.tried        = tried_ff;
      step_in.in_bounds    = inb_ff;
      step_in.target_empty = grid_rd_ff == CW'(0);
      step_in.stack_room   = depth_ff < CW'(PATH_LEN);
      step_in.stack_empty  = depth_ff == CW'(0);
      step_in.top_dir      = stk_rd_ff[5:4];
      step_in.top_tried    = stk_rd_ff[3:0];
   end

   bgpw_step u_step (
      .step_i (step_in),
      .step_o (step_out)
   );

   // ---------------------------------------------------------------- next head
   always_comb begin
      head_pos_in = head_pos_ff;
      head_row_in = head_row_ff;
      head_col_in = head_col_ff;
      placed_in   = placed_ff;
      depth_in    = depth_ff;
      unique case (step_out.op)
         bgpw_pkg::OP_ADVANCE: begin
            head_pos_in = addr_ff;
            placed_in   = placed_ff + CW'(1);
            depth_in    = depth_ff + CW'(1);
            case (dir_ff)
               bgpw_pkg::DIR_NORTH: head_row_in = head_row_ff - RW'(1);
               bgpw_pkg::DIR_SOUTH: head_row_in = head_row_ff + RW'(1);
               bgpw_pkg::DIR_EAST:  head_col_in = head_col_ff + RW'(1);
               default:             head_col_in = head_col_ff - RW'(1);
            endcase
         end
         bgpw_pkg::OP_POP: begin
            placed_in = placed_ff - CW'(1);
            depth_in  = depth_ff - CW'(1);
            // step back opposite to the popped move
            case (stk_rd_ff[5:4])
               bgpw_pkg::DIR_NORTH: begin
                  head_row_in = head_row_ff + RW'(1);
                  head_pos_in = head_pos_ff + AW'(GRID_SIDE);
               end
               bgpw_pkg::DIR_SOUTH: begin
                  head_row_in = head_row_ff - RW'(1);
                  head_pos_in = head_pos_ff - AW'(GRID_SIDE);
               end
               bgpw_pkg::DIR_EAST: begin
                  head_col_in = head_col_ff - RW'(1);
                  head_pos_in = head_pos_ff - AW'(1);
               end
               default: begin
                  head_col_in = head_col_ff + RW'(1);
                  head_pos_in = head_pos_ff + AW'(1);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- grid write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = CW'(0);
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_data = (clr_addr_ff == AW'(0)) ? CW'(1) : CW'(0);
      end else if (proc && step_out.op == bgpw_pkg::OP_ADVANCE) begin
         wr_en   = 1'b1;
         wr_addr = addr_ff;
         wr_data = placed_ff + CW'(1);
      end else if (proc && step_out.op == bgpw_pkg::OP_POP) begin
         wr_en   = 1'b1;
         wr_addr = head_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && step_out.op == bgpw_pkg::OP_ADVANCE) begin
         stack_mem[depth_ff[SW-1:0]] <= {dir_ff, step_out.push_tried};
      end
   end

   // ---------------------------------------------------------------- control state
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (proc) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         busy_ff       <= 1'b0;
         head_pos_ff   <= '0;
         head_row_ff   <= '0;
         head_col_ff   <= '0;
         placed_ff     <= CW'(1);
         depth_ff      <= '0;
         tried_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NUM_CELLS - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (proc) begin
            head_pos_ff  <= head_pos_in;
            head_row_ff  <= head_row_in;
            head_col_ff  <= head_col_in;
            placed_ff    <= placed_in;
            depth_ff     <= depth_in;
            tried_ff     <= step_out.tried_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response payload
   always_ff @(posedge clock) begin
      if (proc) begin
         status_ff   <= step_out.status;
         position_ff <= 8'(head_pos_in);
         count_ff    <= 5'(placed_in);
         moved_ff    <= step_out.moved_dir;
         label_ff    <= (act_ff && !rdz_ff) ? 5'(grid_rd_ff) : 5'd0;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.position        = position_ff;
   assign rsp_ch.label_count     = count_ff;
   assign rsp_ch.moved_direction = moved_ff;
   assign rsp_ch.cell_label      = label_ff;

endmodule
